/* hdl/assert_macros.svh */
// Assertion macros shared by the termination vote RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication under an active-low reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/ttv_pkg.sv */
// Shared types and constants for the tree termination vote node.
// No dependencies; imported by ttv_vote, tree_termination_vote and the testbench.
package ttv_pkg;

	localparam int MAX_NODES = 1024;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int CHILD_W   = CNT_W + 1;
	localparam int CNT_DATA_W = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_NODES);

	typedef enum logic [0:0] {
		REG_NODE_INDEX = 1'b0,
		REG_NODE_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_DATA_W-1:0] local_spawned;
		logic [CNT_DATA_W-1:0] local_completed;
		logic [CNT_DATA_W-1:0] left_votes;
		logic [CNT_DATA_W-1:0] right_votes;
		logic [CNT_DATA_W-1:0] parent_votes;
		logic [CNT_DATA_W-1:0] left_spawned;
		logic [CNT_DATA_W-1:0] left_completed;
		logic [CNT_DATA_W-1:0] right_spawned;
		logic [CNT_DATA_W-1:0] right_completed;
		logic                  down_terminated;
		logic [CNT_DATA_W-1:0] down_spawned;
		logic [CNT_DATA_W-1:0] down_completed;
	} ttv_item_t;

	typedef struct packed {
		logic                  done_flag;
		logic                  phase_down;
		logic [CNT_DATA_W-1:0] prev_spawned;
		logic [CNT_DATA_W-1:0] prev_completed;
		logic [CNT_DATA_W-1:0] seen_left;
		logic [CNT_DATA_W-1:0] seen_right;
		logic [CNT_DATA_W-1:0] seen_parent;
	} ttv_state_t;

	typedef struct packed {
		logic                  terminated;
		logic                  send_up;
		logic                  up_to_left_slot;
		logic                  send_down;
		logic                  out_terminated;
		logic [CNT_DATA_W-1:0] out_spawned;
		logic [CNT_DATA_W-1:0] out_completed;
	} ttv_result_t;

endpackage

/* hdl/tree_termination_vote.sv */
// One node of a binary-tree counting termination detector, top level.
// Registers: input, then result; node state updates as a request enters the result register.
// Throughput: one request per cycle unless out_stall holds back a waiting result.
// Reset: arst_n clears node state, valid bits and configuration (node_index 0, node_count 1).
// Depends on ttv_pkg, ttv_vote and assert_macros.svh.
`include "assert_macros.svh"
module tree_termination_vote
	import ttv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [0:0]            cfg_index,
	input  logic [CNT_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CNT_DATA_W-1:0] local_spawned,
	input  logic [CNT_DATA_W-1:0] local_completed,
	input  logic [CNT_DATA_W-1:0] left_votes,
	input  logic [CNT_DATA_W-1:0] right_votes,
	input  logic [CNT_DATA_W-1:0] parent_votes,
	input  logic [CNT_DATA_W-1:0] left_spawned,
	input  logic [CNT_DATA_W-1:0] left_completed,
	input  logic [CNT_DATA_W-1:0] right_spawned,
	input  logic [CNT_DATA_W-1:0] right_completed,
	input  logic                  down_terminated,
	input  logic [CNT_DATA_W-1:0] down_spawned,
	input  logic [CNT_DATA_W-1:0] down_completed,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  terminated,
	output logic                  send_up,
	output logic                  up_to_left_slot,
	output logic                  send_down,
	output logic                  out_terminated,
	output logic [CNT_DATA_W-1:0] out_spawned,
	output logic [CNT_DATA_W-1:0] out_completed
);

	logic [IDX_W-1:0] node_index_q;
	logic [CNT_W-1:0] node_count_q;
	ttv_state_t       state_q;
	ttv_state_t       state_nxt;
	ttv_item_t        item_s1;
	logic             valid_s1;
	ttv_result_t      res_nxt;
	ttv_result_t      res_s2;
	logic             valid_s2;
	logic             adv_s2;
	logic             take_in;

	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_index_q <= '0;
			node_count_q <= CNT_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_NODE_INDEX: node_index_q <= cfg_data[IDX_W-1:0];
				REG_NODE_COUNT: node_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || adv_s2) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{local_spawned, local_completed, left_votes, right_votes,
				parent_votes, left_spawned, left_completed, right_spawned,
				right_completed, down_terminated, down_spawned, down_completed};
		end
	end

	ttv_vote u_vote (
		.node_index (node_index_q),
		.node_count (node_count_q),
		.cur        (state_q),
		.item       (item_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s2) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2 || !out_stall) begin
			valid_s2 <= adv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid       = valid_s2;
	assign terminated      = res_s2.terminated;
	assign send_up         = res_s2.send_up;
	assign up_to_left_slot = res_s2.up_to_left_slot;
	assign send_down       = res_s2.send_down;
	assign out_terminated  = res_s2.out_terminated;
	assign out_spawned     = res_s2.out_spawned;
	assign out_completed   = res_s2.out_completed;

	`ASSERT_NEXT(a_done_sticky, clk, arst_n, state_q.done_flag, state_q.done_flag)
	`ASSERT_IMPLY(a_one_direction, clk, arst_n, valid_s2, !(res_s2.send_up && res_s2.send_down))
	`ASSERT_IMPLY(a_slot_needs_up, clk, arst_n, valid_s2 && res_s2.up_to_left_slot, res_s2.send_up)
	`ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !adv_s2, valid_s1 && $stable(item_s1))

endmodule

/* hdl/ttv_vote.sv */
// Vote decision logic: next node state and outgoing token for one request.
// Depends on ttv_pkg.
module ttv_vote
	import ttv_pkg::*;
(
	input  logic [IDX_W-1:0] node_index,
	input  logic [CNT_W-1:0] node_count,
	input  ttv_state_t       cur,
	input  ttv_item_t        item,
	output ttv_state_t       nxt,
	output ttv_result_t      res
);

	logic [CNT_W-1:0]      count;
	logic [CHILD_W-1:0]    lidx;
	logic [CHILD_W-1:0]    ridx;
	logic                  has_l;
	logic                  has_r;
	logic                  root;
	logic                  single;
	logic                  votes;
	logic                  new_parent;
	logic [CNT_DATA_W-1:0] sum_s;
	logic [CNT_DATA_W-1:0] sum_c;
	logic                  wave_done;

	assign count  = (node_count > COUNT_MAX) ? COUNT_MAX : node_count;
	assign lidx   = CHILD_W'({node_index, 1'b1});
	assign ridx   = lidx + CHILD_W'(1);
	assign has_l  = lidx < CHILD_W'(count);
	assign has_r  = ridx < CHILD_W'(count);
	assign root   = (node_index == '0);
	assign single = (count <= CNT_W'(1));

	assign votes = (!has_l || (item.left_votes > cur.seen_left)) &&
		(!has_r || (item.right_votes > cur.seen_right));
	assign new_parent = root || (item.parent_votes > cur.seen_parent);

	assign sum_s = item.local_spawned + (has_l ? item.left_spawned : '0) +
		(has_r ? item.right_spawned : '0);
	assign sum_c = item.local_completed + (has_l ? item.left_completed : '0) +
		(has_r ? item.right_completed : '0);
	assign wave_done = (sum_s == cur.prev_spawned) && (sum_c == cur.prev_completed) &&
		(sum_s == sum_c);

	always_comb begin
		nxt = cur;
		res = '0;
		if (single) begin
			if ((item.local_spawned == cur.prev_spawned) &&
				(item.local_completed == cur.prev_completed) &&
				(item.local_spawned == item.local_completed)) begin
				nxt.done_flag = 1'b1;
			end
			nxt.prev_spawned   = item.local_spawned;
			nxt.prev_completed = item.local_completed;
		end else if (cur.phase_down) begin
			if (new_parent) begin
				if (!has_l && !has_r) begin
					if (item.down_terminated) begin
						nxt.done_flag = 1'b1;
					end else begin
						res.send_up        = 1'b1;
						res.out_terminated = cur.done_flag;
						res.out_spawned    = item.local_spawned;
						res.out_completed  = item.local_completed;
						nxt.seen_parent    = item.parent_votes;
					end
				end else begin
					if (item.down_terminated) begin
						nxt.done_flag = 1'b1;
					end else begin
						nxt.seen_parent = item.parent_votes;
					end
					res.send_down      = 1'b1;
					res.out_terminated = item.down_terminated;
					res.out_spawned    = item.down_spawned;
					res.out_completed  = item.down_completed;
					nxt.phase_down     = 1'b0;
				end
			end
		end else if (votes) begin
			if (root) begin
				if (wave_done) begin
					nxt.done_flag = 1'b1;
				end
				nxt.prev_spawned   = sum_s;
				nxt.prev_completed = sum_c;
				res.send_down      = 1'b1;
			end else begin
				res.send_up    = 1'b1;
				nxt.phase_down = 1'b1;
			end
			res.out_terminated = nxt.done_flag;
			res.out_spawned    = sum_s;
			res.out_completed  = sum_c;
			if (!nxt.done_flag) begin
				nxt.seen_left  = item.left_votes;
				nxt.seen_right = item.right_votes;
			end
		end
		res.terminated      = nxt.done_flag;
		res.up_to_left_slot = res.send_up && node_index[0];
	end

endmodule

/* tb/sv/tree_termination_vote_test.sv */
// Testbench for tree_termination_vote: drives vote requests across node settings,
// predicts each result from its own copy of the node state and checks every field.
// Depends on ttv_pkg and the tree_termination_vote RTL.
module tree_termination_vote_test;
	import ttv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [0:0]            cfg_index = REG_NODE_INDEX;
	logic [CNT_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	ttv_item_t             req = '0;
	logic                  terminated;
	logic                  send_up;
	logic                  up_to_left_slot;
	logic                  send_down;
	logic                  out_terminated;
	logic [CNT_DATA_W-1:0] out_spawned;
	logic [CNT_DATA_W-1:0] out_completed;

	ttv_item_t   pending_votes[$];
	ttv_result_t expected_votes[$];
	ttv_result_t next_vote;
	ttv_state_t  node_state = '0;
	ttv_state_t  plan_state = '0;
	logic [9:0]  node_index_cfg = '0;
	logic [10:0] node_count_cfg = 11'd1;
	logic [31:0] stable_local;
	logic [31:0] stable_left;
	logic [31:0] stable_right;
	bit          quiet = 1'b0;
	int          mismatch_count = 0;
	int          accepted_count = 0;
	int          result_count = 0;
	int          up_count = 0;
	int          down_count = 0;
	int          phase_count = 0;

	tree_termination_vote u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.local_spawned   (req.local_spawned),
		.local_completed (req.local_completed),
		.left_votes      (req.left_votes),
		.right_votes     (req.right_votes),
		.parent_votes    (req.parent_votes),
		.left_spawned    (req.left_spawned),
		.left_completed  (req.left_completed),
		.right_spawned   (req.right_spawned),
		.right_completed (req.right_completed),
		.down_terminated (req.down_terminated),
		.down_spawned    (req.down_spawned),
		.down_completed  (req.down_completed),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.terminated      (terminated),
		.send_up         (send_up),
		.up_to_left_slot (up_to_left_slot),
		.send_down       (send_down),
		.out_terminated  (out_terminated),
		.out_spawned     (out_spawned),
		.out_completed   (out_completed)
	);

	always #4 clk = ~clk;

	function automatic ttv_result_t vote_step(inout ttv_state_t st, input logic [9:0] idx,
			input logic [10:0] cnt, input ttv_item_t it);
		ttv_result_t r;
		logic [31:0] count;
		logic [31:0] lidx;
		logic [31:0] s;
		logic [31:0] c;
		logic        has_l;
		logic        has_r;
		logic        root;
		logic        votes;
		int          nkids;
		r = '0;
		count = (cnt > MAX_NODES) ? 32'(MAX_NODES) : 32'(cnt);
		lidx = 32'(idx) * 2 + 1;
		has_l = lidx < count;
		has_r = (lidx + 1) < count;
		nkids = int'(has_l) + int'(has_r);
		root = idx == 0;
		if (count <= 1) begin
			if (it.local_spawned == st.prev_spawned && it.local_completed == st.prev_completed
					&& it.local_spawned == it.local_completed)
				st.done_flag = 1'b1;
			st.prev_spawned = it.local_spawned;
			st.prev_completed = it.local_completed;
		end else if (st.phase_down) begin
			if (root || it.parent_votes > st.seen_parent) begin
				if (nkids == 0) begin
					if (it.down_terminated) begin
						st.done_flag = 1'b1;
					end else begin
						r.send_up = 1'b1;
						r.out_terminated = st.done_flag;
						r.out_spawned = it.local_spawned;
						r.out_completed = it.local_completed;
						st.seen_parent = it.parent_votes;
					end
				end else begin
					if (it.down_terminated)
						st.done_flag = 1'b1;
					r.send_down = 1'b1;
					r.out_terminated = it.down_terminated;
					r.out_spawned = it.down_spawned;
					r.out_completed = it.down_completed;
					st.phase_down = 1'b0;
					if (!it.down_terminated)
						st.seen_parent = it.parent_votes;
				end
			end
		end else begin
			if (nkids == 0)
				votes = 1'b1;
			else if (nkids == 1)
				votes = it.left_votes > st.seen_left;
			else
				votes = it.left_votes > st.seen_left && it.right_votes > st.seen_right;
			if (votes) begin
				s = it.local_spawned + (has_l ? it.left_spawned : 32'd0)
					+ (has_r ? it.right_spawned : 32'd0);
				c = it.local_completed + (has_l ? it.left_completed : 32'd0)
					+ (has_r ? it.right_completed : 32'd0);
				if (root) begin
					if (s == st.prev_spawned && c == st.prev_completed && s == c)
						st.done_flag = 1'b1;
					st.prev_spawned = s;
					st.prev_completed = c;
					r.send_down = 1'b1;
					st.phase_down = 1'b0;
				end else begin
					r.send_up = 1'b1;
					st.phase_down = 1'b1;
				end
				r.out_terminated = st.done_flag;
				r.out_spawned = s;
				r.out_completed = c;
				if (!st.done_flag) begin
					st.seen_left = it.left_votes;
					st.seen_right = it.right_votes;
				end
			end
		end
		r.terminated = st.done_flag;
		r.up_to_left_slot = r.send_up & idx[0];
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] next_count(input logic [31:0] seen);
		if (seen >= 32'hFFFF_0000)
			return $urandom_range(0, 15);
		case ($urandom_range(0, 7))
			0, 1: return seen;
			2: return seen - $urandom_range(1, 5);
			3: return seen + $urandom_range(2, 100);
			default: return seen + 1;
		endcase
	endfunction

	function automatic ttv_item_t fill_item(input logic [31:0] w, input logic dterm);
		ttv_item_t it;
		it = '{w, w, w, w, w, w, w, w, w, dterm, w, w};
		return it;
	endfunction

	function automatic ttv_item_t make_vote(input bit allow_term);
		ttv_item_t it;
		if ($urandom_range(0, 99) < 12) begin
			it = '{pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
				pick_word(), pick_word(), pick_word(), 1'($urandom_range(0, 1)), pick_word(),
				pick_word()};
			return it;
		end
		it.left_votes = next_count(plan_state.seen_left);
		it.right_votes = next_count(plan_state.seen_right);
		it.parent_votes = next_count(plan_state.seen_parent);
		if ($urandom_range(0, 1)) begin
			it.local_spawned = stable_local;
			it.local_completed = stable_local;
		end else begin
			it.local_spawned = pick_word();
			it.local_completed = it.local_spawned - $urandom_range(0, 3);
		end
		if ($urandom_range(0, 3) != 0) begin
			it.left_spawned = stable_left;
			it.left_completed = stable_left;
		end else begin
			it.left_spawned = pick_word();
			it.left_completed = pick_word();
		end
		if ($urandom_range(0, 3) != 0) begin
			it.right_spawned = stable_right;
			it.right_completed = stable_right;
		end else begin
			it.right_spawned = pick_word();
			it.right_completed = pick_word();
		end
		if (!allow_term)
			it.down_terminated = 1'($urandom_range(0, 1));
		else if (plan_state.done_flag)
			it.down_terminated = $urandom_range(0, 3) == 0;
		else
			it.down_terminated = $urandom_range(0, 31) == 0;
		it.down_spawned = $urandom;
		it.down_completed = $urandom;
		return it;
	endfunction

	// hold termination back until the late settings, then queue the request
	function automatic void admit(input ttv_item_t it, input bit allow_term);
		ttv_state_t  probe;
		probe = plan_state;
		void'(vote_step(probe, node_index_cfg, node_count_cfg, it));
		if (!allow_term && probe.done_flag && !plan_state.done_flag) begin
			it.down_terminated = 1'b0;
			it.local_completed = it.local_completed ^ 32'd1;
		end
		void'(vote_step(plan_state, node_index_cfg, node_count_cfg, it));
		pending_votes.push_back(it);
	endfunction

	task automatic set_node(input logic [9:0] idx, input logic [10:0] cnt);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_NODE_INDEX;
		cfg_data <= CNT_W'(idx);
		node_index_cfg = idx;
		@(posedge clk);
		cfg_index <= REG_NODE_COUNT;
		cfg_data <= cnt;
		node_count_cfg = cnt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		stable_local = $urandom;
		stable_left = $urandom;
		stable_right = $urandom;
		phase_count++;
	endtask

	task automatic drain();
		while (pending_votes.size() != 0 || expected_votes.size() != 0 || in_valid)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < 50)
			$display("mismatch at result %0d, %s: got %h, want %h", result_count, what, got,
				want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_votes.push_back(vote_step(node_state, node_index_cfg, node_count_cfg,
					req));
				accepted_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_votes.size() != 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
					req <= pending_votes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_votes.size() == 0) begin
					report_mismatch("result with no request pending", 32'd0, 32'd0);
				end else begin
					next_vote = expected_votes.pop_front();
					up_count += next_vote.send_up;
					down_count += next_vote.send_down;
					if (terminated !== next_vote.terminated)
						report_mismatch("terminated", 32'(terminated), 32'(next_vote.terminated));
					if (send_up !== next_vote.send_up)
						report_mismatch("send_up", 32'(send_up), 32'(next_vote.send_up));
					if (up_to_left_slot !== next_vote.up_to_left_slot)
						report_mismatch("up_to_left_slot", 32'(up_to_left_slot),
							32'(next_vote.up_to_left_slot));
					if (send_down !== next_vote.send_down)
						report_mismatch("send_down", 32'(send_down), 32'(next_vote.send_down));
					if (out_terminated !== next_vote.out_terminated)
						report_mismatch("out_terminated", 32'(out_terminated),
							32'(next_vote.out_terminated));
					if (out_spawned !== next_vote.out_spawned)
						report_mismatch("out_spawned", out_spawned, next_vote.out_spawned);
					if (out_completed !== next_vote.out_completed)
						report_mismatch("out_completed", out_completed, next_vote.out_completed);
				end
			end
			out_stall <= !quiet && ($urandom_range(0, 99) < 26);
		end
	end

	initial begin
		logic [9:0]  pat_idx[5]  = '{10'd0, 10'd0, 10'd4, 10'd600, 10'd1023};
		logic [10:0] pat_cnt[5]  = '{11'd0, 11'd2047, 11'd10, 11'd100, 11'd1024};
		logic [9:0]  run_idx[13] = '{10'd0, 10'd600, 10'd3, 10'd4, 10'd0, 10'd0, 10'd1023,
			10'd511, 10'd0, 10'd2, 10'd0, 10'd6, 10'd1};
		logic [10:0] run_cnt[13] = '{11'd7, 11'd100, 11'd9, 11'd10, 11'd2, 11'd1, 11'd1024,
			11'd2047, 11'd0, 11'd5, 11'd1024, 11'd13, 11'd1024};
		int          run_len[13] = '{250, 150, 200, 200, 150, 150, 150, 200, 100, 100, 150,
			100, 100};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 5; p++) begin
			set_node(pat_idx[p], pat_cnt[p]);
			admit(fill_item(32'h0000_0000, 1'b0), 1'b0);
			admit(fill_item(32'hFFFF_FFFF, 1'b1), 1'b0);
			admit(fill_item(32'hAAAA_AAAA, 1'b0), 1'b0);
			admit(fill_item(32'h5555_5555, 1'b1), 1'b0);
			admit(make_vote(1'b0), 1'b0);
			drain();
		end
		for (int p = 0; p < 13; p++) begin
			quiet = (p == 3 || p == 4);
			set_node(run_idx[p], run_cnt[p]);
			for (int n = 0; n < run_len[p]; n++)
				admit(make_vote(p >= 10), p >= 10);
			drain();
		end
		$display("Ran %0d vote requests over %0d node settings, single node up to 1024-node trees.",
			accepted_count, phase_count);
		$display("Tokens checked: %0d sent up, %0d sent down; termination %0s.", up_count,
			down_count, node_state.done_flag ? "detected" : "not reached");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out waiting for results");
		$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/ttv_pkg.sv
hdl/ttv_vote.sv
hdl/tree_termination_vote.sv
tb/sv/tree_termination_vote_test.sv
